// ----- design/msp_pkg.sv -----
`timescale 1ns / 1ps

package msp_pkg;

    // Profile constants
    localparam int PROFILE_LEN_MAX = 215;
    localparam int FRAC_BITS       = 8;
    localparam int RAMP_SHIFT      = 16 - FRAC_BITS;

    // Field widths
    localparam int TGT_W   = 16;
    localparam int SP_W    = 24;
    localparam int IDX_W   = 8;
    localparam int ACC_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int HOLD_W  = 5;
    localparam int HALF_W  = 7;
    localparam int LEN_W   = 9;
    localparam int RAD_W   = GAIN_W + TGT_W;
    localparam int U2_W    = 2 * HALF_W;
    localparam int PROD_W  = ACC_W + U2_W;
    localparam int CALC_W  = 34;

    // APB
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_LIN_HALF_ACCEL = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ANG_HALF_ACCEL = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LIN_ROOT_GAIN  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ANG_ROOT_GAIN  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HOLD_TICKS     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MAX_HALF_TICKS = 3'd5;

    // Opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef logic signed [TGT_W-1:0] tgt_t;
    typedef logic signed [SP_W-1:0]  sp_t;
    typedef logic [IDX_W-1:0]        idx_t;

    typedef struct packed {
        logic [ACC_W-1:0]  lin_half_accel;
        logic [ACC_W-1:0]  ang_half_accel;
        logic [GAIN_W-1:0] lin_root_gain;
        logic [GAIN_W-1:0] ang_root_gain;
        logic [HOLD_W-1:0] hold_ticks;
        logic [HALF_W-1:0] max_half_ticks;
    } cfg_t;

    typedef struct packed {
        logic start_load;
        logic sqrt_init;
        logic sqrt_step;
        logic start_commit;
        logic tick_load;
        logic tick_mul;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic sqrt_last;
    } stat_t;

endpackage

// ----- design/msp_in_if.sv -----
`timescale 1ns / 1ps

interface msp_in_if;
    import msp_pkg::*;

    logic valid;
    logic ready;
    logic opcode;
    tgt_t target_distance;
    tgt_t target_angle;

    modport source (output valid, output opcode, output target_distance,
                    output target_angle, input ready);
    modport sink   (input valid, input opcode, input target_distance,
                    input target_angle, output ready);
endinterface

// ----- design/msp_out_if.sv -----
`timescale 1ns / 1ps

interface msp_out_if;
    import msp_pkg::*;

    logic valid;
    logic ready;
    sp_t  lin_setpoint;
    sp_t  ang_setpoint;
    logic active;
    logic last;
    idx_t tick_index;

    modport source (output valid, output lin_setpoint, output ang_setpoint,
                    output active, output last, output tick_index, input ready);
    modport sink   (input valid, input lin_setpoint, input ang_setpoint,
                    input active, input last, input tick_index, output ready);
endinterface

// ----- design/msp_cfg.sv -----
`timescale 1ns / 1ps

module msp_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [msp_pkg::APB_AW-1:0]   paddr,
    input  logic [msp_pkg::APB_DW-1:0]   pwdata,
    output logic [msp_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output msp_pkg::cfg_t                cfg
);
    import msp_pkg::*;

    cfg_t                 cfg_reg;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx    = paddr[APB_AW-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.lin_half_accel <= ACC_W'(164);
            cfg_reg.ang_half_accel <= ACC_W'(1707);
            cfg_reg.lin_root_gain  <= GAIN_W'(12800);
            cfg_reg.ang_root_gain  <= GAIN_W'(1229);
            cfg_reg.hold_ticks     <= HOLD_W'(15);
            cfg_reg.max_half_ticks <= HALF_W'(100);
        end
        else if (wr_en) begin
            unique case (idx)
                REG_LIN_HALF_ACCEL: cfg_reg.lin_half_accel <= pwdata[ACC_W-1:0];
                REG_ANG_HALF_ACCEL: cfg_reg.ang_half_accel <= pwdata[ACC_W-1:0];
                REG_LIN_ROOT_GAIN:  cfg_reg.lin_root_gain  <= pwdata[GAIN_W-1:0];
                REG_ANG_ROOT_GAIN:  cfg_reg.ang_root_gain  <= pwdata[GAIN_W-1:0];
                REG_HOLD_TICKS:     cfg_reg.hold_ticks     <= pwdata[HOLD_W-1:0];
                REG_MAX_HALF_TICKS: cfg_reg.max_half_ticks <= pwdata[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_LIN_HALF_ACCEL: prdata = APB_DW'(cfg_reg.lin_half_accel);
            REG_ANG_HALF_ACCEL: prdata = APB_DW'(cfg_reg.ang_half_accel);
            REG_LIN_ROOT_GAIN:  prdata = APB_DW'(cfg_reg.lin_root_gain);
            REG_ANG_ROOT_GAIN:  prdata = APB_DW'(cfg_reg.ang_root_gain);
            REG_HOLD_TICKS:     prdata = APB_DW'(cfg_reg.hold_ticks);
            REG_MAX_HALF_TICKS: prdata = APB_DW'(cfg_reg.max_half_ticks);
            default:            prdata = '0;
        endcase
    end

endmodule

// ----- design/msp_ctrl.sv -----
`timescale 1ns / 1ps

module msp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_opcode,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  msp_pkg::stat_t stat,
    output msp_pkg::cmd_t  cmd
);
    import msp_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SQRT = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;
    localparam logic [2:0] S_TMUL = 3'd4;
    localparam logic [2:0] S_TOUT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       in_acc;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    if (in_opcode == OP_START) begin
                        cmd.start_load = 1'b1;
                        state_next     = S_MUL;
                    end
                    else begin
                        cmd.tick_load = 1'b1;
                        state_next    = S_TMUL;
                    end
                end
            end
            S_MUL: begin
                cmd.sqrt_init = 1'b1;
                state_next    = S_SQRT;
            end
            S_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (stat.sqrt_last)
                    state_next = S_DONE;
            end
            S_DONE: begin
                cmd.start_commit = 1'b1;
                state_next       = S_IDLE;
            end
            S_TMUL: begin
                cmd.tick_mul = 1'b1;
                state_next   = S_TOUT;
            end
            S_TOUT: begin
                // wait for the output register to drain
                if (!out_valid_reg || out_ready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- design/msp_dp.sv -----
`timescale 1ns / 1ps

module msp_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  msp_pkg::cfg_t  cfg,
    input  msp_pkg::cmd_t  cmd,
    output msp_pkg::stat_t stat,
    input  msp_pkg::tgt_t  target_distance,
    input  msp_pkg::tgt_t  target_angle,
    output msp_pkg::sp_t   lin_setpoint,
    output msp_pkg::sp_t   ang_setpoint,
    output logic           active,
    output logic           last,
    output msp_pkg::idx_t  tick_index
);
    import msp_pkg::*;

    localparam logic [RAD_W-1:0] SQRT_BIT0 = RAD_W'(1) << (RAD_W - 2);
    localparam logic signed [CALC_W-1:0] SP_HI = CALC_W'((64'sd1 <<< (SP_W - 1)) - 64'sd1);
    localparam logic signed [CALC_W-1:0] SP_LO = CALC_W'(-(64'sd1 <<< (SP_W - 1)));
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PROFILE_LEN_MAX);

    // move state
    logic              turn_mode_reg;
    logic              move_sign_reg;
    tgt_t              target_reg;
    logic [HALF_W-1:0] half_ticks_reg;
    idx_t              tick_count_reg;
    logic              running_reg;

    // square root unit
    logic [TGT_W-1:0]  mag_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [RAD_W-1:0]  root_reg;
    logic [RAD_W-1:0]  bit_reg;

    // tick pipeline
    logic              act_reg, fin_reg, ramp_reg, first_reg;
    idx_t              t_reg;
    logic [U2_W-1:0]   u2_reg;
    logic [PROD_W-1:0] prod_reg;

    // output register
    sp_t               lin_reg, ang_reg;
    logic              active_reg, last_reg;
    idx_t              idx_reg;

    // start decode
    tgt_t             sel_tgt;
    logic             is_turn;
    logic [TGT_W-1:0] sel_mag;

    assign is_turn = (target_angle != '0);
    assign sel_tgt = is_turn ? target_angle : target_distance;
    assign sel_mag = sel_tgt[TGT_W-1] ? (~sel_tgt + TGT_W'(1)) : sel_tgt;

    // one root bit per step
    logic [RAD_W:0]   trial;
    logic             trial_ge;
    logic [RAD_W-1:0] root_step, rad_step;
    logic [HALF_W-1:0] half_new;

    assign trial     = {1'b0, root_reg} + {1'b0, bit_reg};
    assign trial_ge  = ({1'b0, rad_reg} >= trial);
    assign root_step = trial_ge ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);
    assign rad_step  = trial_ge ? (rad_reg - trial[RAD_W-1:0]) : rad_reg;
    assign half_new  = (root_reg[RAD_W-1:3] > (RAD_W-3)'(cfg.max_half_ticks))
                       ? cfg.max_half_ticks : root_reg[HALF_W+2:3];
    assign stat.sqrt_last = bit_reg[0];

    // tick phase decode
    logic [LEN_W-1:0]  t9, m9, twom, len_raw, len;
    logic [LEN_W-1:0]  u9;
    logic [HALF_W-1:0] u;
    logic              act, fin, ramp, first;

    always_comb begin
        t9      = LEN_W'(tick_count_reg);
        m9      = LEN_W'(half_ticks_reg);
        twom    = m9 << 1;
        len_raw = twom + LEN_W'(cfg.hold_ticks);
        len     = (len_raw > LEN_MAX) ? LEN_MAX : len_raw;
        act     = running_reg && (t9 < len);
        fin     = act && ((t9 + LEN_W'(1)) == len);
        ramp    = t9 < twom;
        first   = t9 < m9;
        u9      = first ? t9 : (twom - LEN_W'(1) - t9);
        u       = u9[HALF_W-1:0];
    end

    // setpoint assembly
    logic [ACC_W-1:0]          h;
    logic signed [CALC_W-1:0]  ramp_mag, ramp_s, tq, sp, sp_sat;

    assign h = turn_mode_reg ? cfg.ang_half_accel : cfg.lin_half_accel;

    always_comb begin
        ramp_mag = $signed(CALC_W'(prod_reg >> RAMP_SHIFT));
        ramp_s   = move_sign_reg ? -ramp_mag : ramp_mag;
        tq       = CALC_W'(target_reg) <<< FRAC_BITS;
        if (ramp_reg)
            sp = first_reg ? ramp_s : (tq - ramp_s);
        else
            sp = tq;
        if (sp > SP_HI)
            sp_sat = SP_HI;
        else if (sp < SP_LO)
            sp_sat = SP_LO;
        else
            sp_sat = sp;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            turn_mode_reg  <= 1'b0;
            move_sign_reg  <= 1'b0;
            target_reg     <= '0;
            half_ticks_reg <= '0;
            tick_count_reg <= '0;
            running_reg    <= 1'b0;
        end
        else begin
            if (cmd.start_load) begin
                turn_mode_reg  <= is_turn;
                move_sign_reg  <= sel_tgt[TGT_W-1];
                target_reg     <= sel_tgt;
                tick_count_reg <= '0;
                running_reg    <= 1'b1;
            end
            if (cmd.start_commit)
                half_ticks_reg <= half_new;
            if (cmd.tick_load) begin
                if (!act || fin)
                    running_reg <= 1'b0;
                if (tick_count_reg != '1)
                    tick_count_reg <= tick_count_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.start_load) begin
            mag_reg  <= sel_mag;
            gain_reg <= is_turn ? cfg.ang_root_gain : cfg.lin_root_gain;
        end
        if (cmd.sqrt_init) begin
            rad_reg  <= RAD_W'(gain_reg) * RAD_W'(mag_reg);
            root_reg <= '0;
            bit_reg  <= SQRT_BIT0;
        end
        if (cmd.sqrt_step) begin
            rad_reg  <= rad_step;
            root_reg <= root_step;
            bit_reg  <= bit_reg >> 2;
        end
        if (cmd.tick_load) begin
            act_reg   <= act;
            fin_reg   <= fin;
            ramp_reg  <= act && ramp;
            first_reg <= first;
            t_reg     <= tick_count_reg;
            u2_reg    <= U2_W'(u) * U2_W'(u);
        end
        if (cmd.tick_mul)
            prod_reg <= PROD_W'(h) * PROD_W'(u2_reg);
        if (cmd.out_load) begin
            lin_reg    <= turn_mode_reg ? '0 : sp_sat[SP_W-1:0];
            ang_reg    <= turn_mode_reg ? sp_sat[SP_W-1:0] : '0;
            active_reg <= act_reg;
            last_reg   <= fin_reg;
            idx_reg    <= t_reg;
        end
    end

    assign lin_setpoint = lin_reg;
    assign ang_setpoint = ang_reg;
    assign active       = active_reg;
    assign last         = last_reg;
    assign tick_index   = idx_reg;

endmodule

// ----- design/motion_setpoint_profile_generator.sv -----
`timescale 1ns / 1ps
// Start transaction: no result; in_ready stays low from acceptance through the half-time commit
//   (operand latch, gain*|target| multiply, 16-step restoring square root
//   at one root bit per cycle, half-time clamp).
// Tick transaction: phase decode + u*u, accel multiply, then setpoint assembly into the output
//   register once it drains; the next transaction is accepted after the result is loaded.
// Output register holds a result until taken; a start may be accepted meanwhile.
// rst_n asynchronous, active low: control, config and move registers reset, no move running.
module motion_setpoint_profile_generator (
    input  logic                        clk,
    input  logic                        rst_n,
    msp_in_if.sink                      in_ch,
    msp_out_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [msp_pkg::APB_AW-1:0]  paddr,
    input  logic [msp_pkg::APB_DW-1:0]  pwdata,
    output logic [msp_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import msp_pkg::*;

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    msp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    msp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_opcode (in_ch.opcode),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    msp_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .cmd             (cmd),
        .stat            (stat),
        .target_distance (in_ch.target_distance),
        .target_angle    (in_ch.target_angle),
        .lin_setpoint    (out_ch.lin_setpoint),
        .ang_setpoint    (out_ch.ang_setpoint),
        .active          (out_ch.active),
        .last            (out_ch.last),
        .tick_index      (out_ch.tick_index)
    );

endmodule

// ----- design/msp_chk.sv -----
`timescale 1ns / 1ps

module msp_chk (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input msp_pkg::sp_t        lin_setpoint,
    input msp_pkg::sp_t        ang_setpoint,
    input logic                active,
    input logic                last
);
    import msp_pkg::*;

    // a pending result is not dropped
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // one transaction at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a transaction is in flight");

    a_last_in_profile: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> active)
        else $error("last flagged outside the profile");

    // only one axis moves
    a_one_axis: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (lin_setpoint == '0) || (ang_setpoint == '0))
        else $error("both axes nonzero");

endmodule

bind motion_setpoint_profile_generator msp_chk u_msp_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .lin_setpoint (out_ch.lin_setpoint),
    .ang_setpoint (out_ch.ang_setpoint),
    .active       (out_ch.active),
    .last         (out_ch.last)
);
